>>> sv/m4inv_pkg.sv
// shared types, constants and helper functions for the 4x4 matrix inverse core
`default_nettype none
package m4inv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int IDX_W     = 4;
    localparam int N_ELEM    = 16;
    localparam int COF_W     = 64;
    localparam int ACC_W     = 100;
    localparam int THR_W     = 17;
    localparam int QUO_W     = COF_W + FRAC_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_ELEM - 1);

    typedef struct packed {
        logic signed [ELEM_W-1:0] element_value;
        logic [IDX_W-1:0]         element_index;
    } in_item_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] result_value;
        logic [IDX_W-1:0]         result_index;
        logic                     invertible;
        logic                     last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RA,
        ST_RB,
        ST_RC,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_COF_WR,
        ST_DR,
        ST_DL,
        ST_DET,
        ST_INV,
        ST_ER,
        ST_EL,
        ST_EDIV,
        ST_EOUT
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] m_raddr;
        logic [IDX_W-1:0] c_raddr;
        logic [IDX_W-1:0] idx;
        logic             ld_a;
        logic             ld_b;
        logic             ld_c_m;
        logic             ld_p_ab;
        logic             ld_p_cof;
        logic             mul_lo;
        logic             acc_add;
        logic             acc_neg;
        logic             acc_clr;
        logic             cof_wr;
        logic             det_wr;
        logic             inv_wr;
        logic             ld_elem;
        logic             div_start;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic inv;
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic logic [COF_W-1:0] mag64(input logic signed [COF_W-1:0] v);
        logic [COF_W-1:0] u;
        u = v;
        return v[COF_W-1] ? (~u + COF_W'(1)) : u;
    endfunction

    // column order of the six terms of a 3x3 determinant, packed {p2, p1, p0}
    function automatic logic [5:0] perm_row(input logic [2:0] t);
        logic [5:0] r;
        case (t)
            3'd0:    r = {2'd2, 2'd1, 2'd0};
            3'd1:    r = {2'd0, 2'd2, 2'd1};
            3'd2:    r = {2'd1, 2'd0, 2'd2};
            3'd3:    r = {2'd0, 2'd1, 2'd2};
            3'd4:    r = {2'd1, 2'd2, 2'd0};
            3'd5:    r = {2'd2, 2'd0, 2'd1};
            default: r = {2'd2, 2'd1, 2'd0};
        endcase
        return r;
    endfunction

    // address of factor sel of term t of the minor for adjugate entry k
    function automatic logic [IDX_W-1:0] minor_addr(input logic [IDX_W-1:0] k,
                                                    input logic [2:0] t,
                                                    input logic [1:0] sel);
        logic [1:0] rsel;
        logic [1:0] p;
        logic [1:0] csel;
        logic [5:0] row;
        rsel = (sel >= k[1:0]) ? sel + 2'd1 : sel;
        row  = perm_row(t);
        p    = row[sel*2 +: 2];
        csel = (p >= k[3:2]) ? p + 2'd1 : p;
        return {rsel, csel};
    endfunction

endpackage
`default_nettype wire

>>> sv/m4inv_ram.sv
// generic single write port ram with registered read
`default_nettype none
module m4inv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> sv/m4inv_div.sv
// restoring divider: round(num * 2^frac / den), ties away from zero, saturated
`default_nettype none
module m4inv_div (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [m4inv_pkg::COF_W-1:0]     num,
    input  wire logic signed [m4inv_pkg::COF_W-1:0]     den,
    output logic                                        done,
    output logic signed [m4inv_pkg::ELEM_W-1:0]         quo
);

    localparam int QW = m4inv_pkg::QUO_W;
    localparam int CW = m4inv_pkg::COF_W;
    localparam int NW = $clog2(QW);
    localparam int F  = m4inv_pkg::FRAC_BITS;
    localparam int EW = m4inv_pkg::ELEM_W;

    logic          busy_reg, busy_next;
    logic          fin_reg, fin_next;
    logic          done_reg, done_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0] n_reg, n_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [EW-1:0] quo_reg, quo_next;

    logic [CW:0]   r_sh;
    logic          rnd;
    logic [QW:0]   q_rnd;
    logic [QW:0]   limit;
    logic [QW:0]   q_sat;

    always_comb
    begin
        r_sh  = {r_reg, n_reg[QW-1]};
        rnd   = {r_reg, 1'b0} >= {1'b0, d_reg};
        q_rnd = {1'b0, q_reg} + (QW+1)'(rnd);
        limit = neg_reg ? (QW+1)'(33'h080000000) : (QW+1)'(33'h07fffffff);
        q_sat = (q_rnd > limit) ? limit : q_rnd;
    end

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = {m4inv_pkg::mag64(num), F'(0)};
            q_next    = '0;
            r_next    = '0;
            d_next    = m4inv_pkg::mag64(den);
            neg_next  = num[CW-1] ^ den[CW-1];
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[QW-2:0], 1'b0};
            if (r_sh >= {1'b0, d_reg})
            begin
                r_next = CW'(r_sh - {1'b0, d_reg});
                q_next = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh[CW-1:0];
                q_next = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + NW'(1);
            if (cnt_reg == NW'(QW - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            quo_next  = neg_reg ? (~q_sat[EW-1:0] + EW'(1)) : q_sat[EW-1:0];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

>>> sv/m4inv_datapath.sv
// matrix and cofactor stores, multipliers, accumulator, divider and output register
`default_nettype none
module m4inv_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_we,
    input  wire m4inv_pkg::in_item_t               in_item,
    input  wire logic                              cfg_we,
    input  wire logic [m4inv_pkg::THR_W-1:0]       cfg_data,
    input  wire m4inv_pkg::cmd_t                   cmd,
    output m4inv_pkg::sts_t                        sts,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output m4inv_pkg::out_item_t                   out_item
);

    localparam int AW = m4inv_pkg::ACC_W;
    localparam int CW = m4inv_pkg::COF_W;
    localparam int EW = m4inv_pkg::ELEM_W;
    localparam int TW = m4inv_pkg::THR_W;
    localparam int F  = m4inv_pkg::FRAC_BITS;
    localparam logic signed [AW-1:0] COF_BIAS = AW'(1) <<< (2*F - 1);
    localparam logic signed [AW-1:0] DET_BIAS = AW'(1) <<< (F - 1);

    logic [EW-1:0]            m_rdata;
    logic [CW-1:0]            c_rdata;

    logic signed [EW-1:0]     op_a_reg, op_b_reg, op_c_reg, elem_reg;
    logic signed [CW-1:0]     prod_reg;
    logic signed [CW:0]       part_reg;
    logic signed [AW-1:0]     acc_reg, acc_next;
    logic signed [CW-1:0]     det_reg;
    logic                     inv_reg;
    logic [TW-1:0]            thr_reg;
    logic                     out_valid_reg, out_valid_next;
    m4inv_pkg::out_item_t     out_reg, out_next;

    logic signed [CW-1:0]     hi_prod;
    logic signed [AW-1:0]     term_w;
    logic signed [AW-1:0]     cof_sh, det_sh;
    logic signed [CW-1:0]     cof_sat, det_sat;
    logic                     div_done;
    logic signed [EW-1:0]     div_quo;

    m4inv_ram #(.WIDTH(EW), .DEPTH(m4inv_pkg::N_ELEM)) u_mat_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_item.element_index),
        .wdata (in_item.element_value),
        .raddr (cmd.m_raddr),
        .rdata (m_rdata)
    );

    m4inv_ram #(.WIDTH(CW), .DEPTH(m4inv_pkg::N_ELEM)) u_cof_ram (
        .clk   (clk),
        .we    (cmd.cof_wr),
        .waddr (cmd.idx),
        .wdata (cof_sat),
        .raddr (cmd.c_raddr),
        .rdata (c_rdata)
    );

    m4inv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (c_rdata),
        .den   (det_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        hi_prod = $signed(prod_reg[CW-1:EW]) * op_c_reg;
        term_w  = (AW'(hi_prod) <<< EW) + AW'(part_reg);
        cof_sh  = (acc_reg + COF_BIAS) >>> (2*F);
        det_sh  = (acc_reg + DET_BIAS) >>> F;
        if ((&cof_sh[AW-1:CW-1]) || !(|cof_sh[AW-1:CW-1]))
        begin
            cof_sat = cof_sh[CW-1:0];
        end
        else
        begin
            cof_sat = cof_sh[AW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        if ((&det_sh[AW-1:CW-1]) || !(|det_sh[AW-1:CW-1]))
        begin
            det_sat = det_sh[CW-1:0];
        end
        else
        begin
            det_sat = det_sh[AW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clr)
        begin
            acc_next = '0;
        end
        else if (cmd.acc_add)
        begin
            acc_next = cmd.acc_neg ? acc_reg - term_w : acc_reg + term_w;
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_next.result_value = inv_reg ? div_quo : elem_reg;
            out_next.result_index = cmd.idx;
            out_next.invertible   = inv_reg;
            out_next.last         = (cmd.idx == m4inv_pkg::LAST_IDX);
            out_valid_next        = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            det_reg       <= '0;
            inv_reg       <= 1'b0;
            thr_reg       <= TW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cmd.det_wr)
            begin
                det_reg <= det_sat;
            end
            if (cmd.inv_wr)
            begin
                inv_reg <= m4inv_pkg::mag64(det_reg) > CW'(thr_reg);
            end
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.ld_a)
        begin
            op_a_reg <= m_rdata;
        end
        if (cmd.ld_b)
        begin
            op_b_reg <= m_rdata;
        end
        if (cmd.ld_c_m)
        begin
            op_c_reg <= m_rdata;
        end
        if (cmd.ld_elem)
        begin
            elem_reg <= m_rdata;
        end
        if (cmd.ld_p_ab)
        begin
            prod_reg <= op_a_reg * op_b_reg;
        end
        else if (cmd.ld_p_cof)
        begin
            prod_reg <= c_rdata;
        end
        if (cmd.mul_lo)
        begin
            part_reg <= $signed({1'b0, prod_reg[EW-1:0]}) * op_c_reg;
        end
    end

    assign sts.inv      = inv_reg;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign out_item     = out_reg;

endmodule
`default_nettype wire

>>> sv/m4inv_ctrl.sv
// sequencer for cofactor, determinant and result phases
`default_nettype none
module m4inv_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [m4inv_pkg::IDX_W-1:0]   in_index,
    output logic                               in_stall,
    input  wire m4inv_pkg::sts_t               sts,
    output m4inv_pkg::cmd_t                    cmd
);

    localparam int IW = m4inv_pkg::IDX_W;

    m4inv_pkg::state_t state_reg, state_next;
    logic [IW-1:0]     k_reg, k_next;
    logic [2:0]        t_reg, t_next;
    logic [1:0]        j_reg, j_next;
    logic              det_ph_reg, det_ph_next;

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        t_next      = t_reg;
        j_next      = j_reg;
        det_ph_next = det_ph_reg;
        case (state_reg)
            m4inv_pkg::ST_IDLE:
            begin
                if (in_valid && in_index == m4inv_pkg::LAST_IDX)
                begin
                    state_next  = m4inv_pkg::ST_RA;
                    k_next      = '0;
                    t_next      = '0;
                    det_ph_next = 1'b0;
                end
            end
            m4inv_pkg::ST_RA: state_next = m4inv_pkg::ST_RB;
            m4inv_pkg::ST_RB: state_next = m4inv_pkg::ST_RC;
            m4inv_pkg::ST_RC: state_next = m4inv_pkg::ST_M1;
            m4inv_pkg::ST_M1: state_next = m4inv_pkg::ST_M2;
            m4inv_pkg::ST_M2: state_next = m4inv_pkg::ST_M3;
            m4inv_pkg::ST_M3:
            begin
                if (det_ph_reg)
                begin
                    if (j_reg == 2'd3)
                    begin
                        state_next = m4inv_pkg::ST_DET;
                    end
                    else
                    begin
                        j_next     = j_reg + 2'd1;
                        state_next = m4inv_pkg::ST_DR;
                    end
                end
                else if (t_reg == 3'd5)
                begin
                    state_next = m4inv_pkg::ST_COF_WR;
                end
                else
                begin
                    t_next     = t_reg + 3'd1;
                    state_next = m4inv_pkg::ST_RA;
                end
            end
            m4inv_pkg::ST_COF_WR:
            begin
                t_next = '0;
                if (k_reg == m4inv_pkg::LAST_IDX)
                begin
                    det_ph_next = 1'b1;
                    j_next      = '0;
                    state_next  = m4inv_pkg::ST_DR;
                end
                else
                begin
                    k_next     = k_reg + IW'(1);
                    state_next = m4inv_pkg::ST_RA;
                end
            end
            m4inv_pkg::ST_DR:  state_next = m4inv_pkg::ST_DL;
            m4inv_pkg::ST_DL:  state_next = m4inv_pkg::ST_M2;
            m4inv_pkg::ST_DET: state_next = m4inv_pkg::ST_INV;
            m4inv_pkg::ST_INV:
            begin
                k_next     = '0;
                state_next = m4inv_pkg::ST_ER;
            end
            m4inv_pkg::ST_ER: state_next = m4inv_pkg::ST_EL;
            m4inv_pkg::ST_EL:
            begin
                state_next = sts.inv ? m4inv_pkg::ST_EDIV : m4inv_pkg::ST_EOUT;
            end
            m4inv_pkg::ST_EDIV:
            begin
                if (sts.div_done)
                begin
                    state_next = m4inv_pkg::ST_EOUT;
                end
            end
            m4inv_pkg::ST_EOUT:
            begin
                if (sts.out_free)
                begin
                    if (k_reg == m4inv_pkg::LAST_IDX)
                    begin
                        det_ph_next = 1'b0;
                        state_next  = m4inv_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = m4inv_pkg::ST_ER;
                    end
                end
            end
            default: state_next = m4inv_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        cmd.idx = k_reg;
        case (state_reg)
            m4inv_pkg::ST_IDLE: cmd.acc_clr = 1'b1;
            m4inv_pkg::ST_RA:   cmd.m_raddr = m4inv_pkg::minor_addr(k_reg, t_reg, 2'd0);
            m4inv_pkg::ST_RB:
            begin
                cmd.m_raddr = m4inv_pkg::minor_addr(k_reg, t_reg, 2'd1);
                cmd.ld_a    = 1'b1;
            end
            m4inv_pkg::ST_RC:
            begin
                cmd.m_raddr = m4inv_pkg::minor_addr(k_reg, t_reg, 2'd2);
                cmd.ld_b    = 1'b1;
            end
            m4inv_pkg::ST_M1:
            begin
                cmd.ld_c_m  = 1'b1;
                cmd.ld_p_ab = 1'b1;
            end
            m4inv_pkg::ST_M2: cmd.mul_lo = 1'b1;
            m4inv_pkg::ST_M3:
            begin
                cmd.acc_add = 1'b1;
                cmd.acc_neg = !det_ph_reg && ((t_reg >= 3'd3) ^ k_reg[0] ^ k_reg[2]);
            end
            m4inv_pkg::ST_COF_WR:
            begin
                cmd.cof_wr  = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            m4inv_pkg::ST_DR:
            begin
                cmd.m_raddr = {2'b00, j_reg};
                cmd.c_raddr = {j_reg, 2'b00};
            end
            m4inv_pkg::ST_DL:
            begin
                cmd.ld_c_m   = 1'b1;
                cmd.ld_p_cof = 1'b1;
            end
            m4inv_pkg::ST_DET:
            begin
                cmd.det_wr  = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            m4inv_pkg::ST_INV: cmd.inv_wr = 1'b1;
            m4inv_pkg::ST_ER:
            begin
                cmd.m_raddr = k_reg;
                cmd.c_raddr = k_reg;
            end
            m4inv_pkg::ST_EL:
            begin
                cmd.ld_elem   = 1'b1;
                cmd.div_start = sts.inv;
            end
            m4inv_pkg::ST_EDIV: cmd.idx = k_reg;
            m4inv_pkg::ST_EOUT: cmd.out_load = sts.out_free;
            default: cmd.acc_clr = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= m4inv_pkg::ST_IDLE;
            k_reg      <= '0;
            t_reg      <= '0;
            j_reg      <= '0;
            det_ph_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            t_reg      <= t_next;
            j_reg      <= j_next;
            det_ph_reg <= det_ph_next;
        end
    end

    assign in_stall = (state_reg != m4inv_pkg::ST_IDLE);

endmodule
`default_nettype wire

>>> sv/matrix_4x4_inverse_core.sv
// top level of the 4x4 fixed-point matrix inverse core
`default_nettype none
// Elements are written one per cycle by row-major index while in_stall is low; writing
// index 15 starts a run and holds in_stall high until all sixteen results have been
// handed to the output register. A run builds the cofactors (six triple products each,
// 32-bit multipliers, one matrix read port), then the determinant and the singularity
// check, and then each result by a short path for a singular matrix or by the divider
// (one quotient bit a cycle) for an invertible one, in Q16.16. Every element must have
// been written before index 15 arrives. The user writes the threshold register only
// while no run is in progress; the block itself does not enforce this.
module matrix_4x4_inverse_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire m4inv_pkg::in_item_t               in_item,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output m4inv_pkg::out_item_t                   out_item,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [m4inv_pkg::THR_W-1:0]       cfg_data
);

    m4inv_pkg::cmd_t cmd;
    m4inv_pkg::sts_t sts;
    logic            in_we;

    assign in_we     = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    m4inv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_index (in_item.element_index),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    m4inv_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_we     (in_we),
        .in_item   (in_item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

`ifndef NO_ASSERTIONS
    a_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_we && in_item.element_index == m4inv_pkg::LAST_IDX) |=> in_stall)
        else $error("run did not start after last element");

    a_rise_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (in_stall || out_item.last))
        else $error("result appeared outside a run");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_item.last) |=>
            (in_stall || (out_valid && out_item.last)))
        else $error("run ended before the last result");
`endif

endmodule
`default_nettype wire

>>> verif/tb_matrix_4x4_inverse_core.sv
// testbench for the 4x4 fixed-point matrix inverse core, checked against its own predictor
`default_nettype none
module tb_matrix_4x4_inverse_core;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int LONG_HOLD = 3000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    m4inv_pkg::in_item_t in_item;
    logic out_valid;
    logic out_stall;
    m4inv_pkg::out_item_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [m4inv_pkg::THR_W-1:0] cfg_data;

    matrix_4x4_inverse_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    m4inv_pkg::in_item_t  elem_q[$];
    m4inv_pkg::out_item_t inverse_due[$];
    logic signed [m4inv_pkg::ELEM_W-1:0] mat[m4inv_pkg::N_ELEM];
    logic [m4inv_pkg::THR_W-1:0] det_limit;
    int errors;
    int items_queued;
    int items_taken;
    int idle_cycles;
    int in_gap;
    int out_gap;
    int hold_cnt;
    bit quiet;
    bit hold_req;
    bit hold_done;
    bit in_taken;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic logic signed [127:0] round_sat64(input logic signed [127:0] v,
                                                        input int sh);
        logic signed [127:0] r;
        r = (v + (128'sd1 <<< (sh - 1))) >>> sh;
        if (r > 128'sd9223372036854775807)
            r = 128'sd9223372036854775807;
        else if (r < -128'sd9223372036854775808)
            r = -128'sd9223372036854775808;
        return r;
    endfunction

    // signed cofactor of element (row, col), scaled back to the element format
    function automatic logic signed [127:0] cofactor_of(input int row, input int col);
        int rr[3];
        int cc[3];
        int pa[6];
        int pb[6];
        int pc[6];
        int k;
        int j;
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        logic signed [127:0] sum;
        pa = '{0, 1, 2, 2, 0, 1};
        pb = '{1, 2, 0, 1, 2, 0};
        pc = '{2, 0, 1, 0, 1, 2};
        k = 0;
        j = 0;
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (i != row)
            begin
                rr[k] = i;
                k++;
            end
            if (i != col)
            begin
                cc[j] = i;
                j++;
            end
        end
        for (int t = 0; t < 6; t++)
        begin
            a = mat[rr[0] * 4 + cc[pa[t]]];
            b = mat[rr[1] * 4 + cc[pb[t]]];
            c = mat[rr[2] * 4 + cc[pc[t]]];
            if (t < 3)
                sum = sum + a * b * c;
            else
                sum = sum - a * b * c;
        end
        if (((row + col) & 1) != 0)
            sum = -sum;
        return round_sat64(sum, 2 * m4inv_pkg::FRAC_BITS);
    endfunction

    function automatic logic [m4inv_pkg::ELEM_W-1:0] divide_sat(
        input logic signed [127:0] num,
        input logic signed [127:0] den);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] lim;
        bit neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0 ? -num : num) << m4inv_pkg::FRAC_BITS;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        if (r >= d - r)
            q = q + 1;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim)
            q = lim;
        if (neg)
            q = -q;
        return q[m4inv_pkg::ELEM_W-1:0];
    endfunction

    task automatic predict_inverse();
        logic signed [127:0] adj[m4inv_pkg::N_ELEM];
        logic signed [127:0] acc;
        logic signed [127:0] det;
        logic [127:0] det_mag;
        m4inv_pkg::out_item_t o;
        bit inv;
        acc = 0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                adj[r * 4 + c] = cofactor_of(c, r);
        for (int i = 0; i < 4; i++)
            acc = acc + 128'(mat[i]) * adj[i * 4];
        det = round_sat64(acc, m4inv_pkg::FRAC_BITS);
        det_mag = det < 0 ? -det : det;
        inv = det_mag > 128'(det_limit);
        for (int i = 0; i < m4inv_pkg::N_ELEM; i++)
        begin
            o.result_value = inv ? divide_sat(adj[i], det) : mat[i];
            o.result_index = m4inv_pkg::IDX_W'(i);
            o.invertible = inv;
            o.last = (i == m4inv_pkg::N_ELEM - 1);
            inverse_due.push_back(o);
        end
    endtask

    // input driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
            in_gap <= 0;
        end
        else if (!in_valid || in_taken)
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                in_valid <= 1'b0;
                in_gap <= $urandom_range(0, 8);
            end
            else if (elem_q.size() > 0)
            begin
                in_valid <= 1'b1;
                in_item <= elem_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output stall control
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_cnt <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end
        else if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap <= out_gap - 1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            out_gap <= $urandom_range(0, 8);
        end
        else
            out_stall <= 1'b0;
    end

    // monitor: predictor update and result checks
    always @(posedge clk)
    begin
        m4inv_pkg::out_item_t want;
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
        begin
            items_taken++;
            mat[in_item.element_index] = in_item.element_value;
            if (in_item.element_index == m4inv_pkg::LAST_IDX)
                predict_inverse();
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (inverse_due.size() == 0)
                report("unexpected item", 64'(out_item), 64'd0);
            else
            begin
                want = inverse_due.pop_front();
                if (out_item.result_value !== want.result_value)
                    report("result_value", 64'(out_item.result_value),
                           64'(want.result_value));
                if (out_item.result_index !== want.result_index)
                    report("result_index", 64'(out_item.result_index),
                           64'(want.result_index));
                if (out_item.invertible !== want.invertible)
                    report("invertible", 64'(out_item.invertible), 64'(want.invertible));
                if (out_item.last !== want.last)
                    report("last", 64'(out_item.last), 64'(want.last));
            end
        end
        if (in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send(input int idx, input logic [31:0] v);
        m4inv_pkg::in_item_t it;
        it.element_index = m4inv_pkg::IDX_W'(idx);
        it.element_value = v;
        elem_q.push_back(it);
        items_queued++;
    endtask

    function automatic logic [31:0] rand_elem(input int kind);
        case (kind)
            0: return 32'($signed($urandom_range(0, 524288)) - 262144);
            1: return $urandom();
            default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    // full load in shuffled order, index 15 last
    task automatic load_matrix(input int kind);
        int order[15];
        int j;
        int tmp;
        logic [31:0] m[16];
        for (int i = 0; i < 16; i++)
        begin
            m[i] = rand_elem(kind == 2 ? 0 : kind);
            if (kind == 0 && i % 5 == 0)
                m[i] = m[i] + 32'd524288;
        end
        if (kind == 2)
            for (int c = 0; c < 4; c++)
                m[12 + c] = m[$urandom_range(0, 2) * 4 + c];
        for (int i = 0; i < 15; i++)
            order[i] = i;
        for (int i = 14; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 15; i++)
            send(order[i], m[order[i]]);
        send(15, m[15]);
    endtask

    // diag(s, 1, 1, 1): determinant lands exactly on s
    task automatic load_edge_matrix();
        logic signed [31:0] s;
        s = 32'(det_limit) + 32'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1)
            s = -s;
        for (int i = 0; i < 15; i++)
            send(i, i == 0 ? s : (i % 5 == 0 ? 32'd65536 : 32'd0));
        send(15, 32'd65536);
    endtask

    task automatic run_random(input int n_items);
        int start;
        int sel;
        start = items_queued;
        while (items_queued - start < n_items)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 3)
                load_matrix(0);
            else if (sel < 5)
            begin
                repeat ($urandom_range(1, 6))
                    send($urandom_range(0, 14), rand_elem($urandom_range(0, 2)));
                send(15, rand_elem($urandom_range(0, 2)));
            end
            else if (sel == 5)
                load_matrix(1);
            else if (sel == 6)
                load_matrix(2);
            else if (sel == 7)
                load_matrix(3);
            else
                load_edge_matrix();
        end
    endtask

    task automatic drain();
        while (items_taken != items_queued || inverse_due.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [m4inv_pkg::THR_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        det_limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        errors = 0;
        items_queued = 0;
        items_taken = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        det_limit = 1;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_threshold(m4inv_pkg::THR_W'(0));
        for (int i = 0; i < 16; i++)
            send(i, i % 5 == 0 ? 32'h0001_0000 : 32'h0);
        send(0, 32'h7FFF_FFFF);
        send(15, 32'h8000_0000);
        send(5, 32'h0);
        send(10, 32'hFFFF_FFFF);
        send(15, 32'h0);
        drain();

        write_threshold(m4inv_pkg::THR_W'(65536));
        run_random(100);
        drain();

        write_threshold(m4inv_pkg::THR_W'(1));
        hold_req = 1'b1;
        run_random(100);
        drain();

        write_threshold(m4inv_pkg::THR_W'($urandom_range(0, 65536)));
        run_random(100);
        drain();

        write_threshold(m4inv_pkg::THR_W'($urandom_range(0, 131071)));
        run_random(80);
        drain();

        quiet = 1'b1;
        write_threshold(m4inv_pkg::THR_W'($urandom_range(0, 200)));
        run_random(60);
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
